[rtl/mfrp_pkg.sv]
// Package for the monochrome rotated frame store engine.
// Holds the request codes, controller states, command/status structs and byte constants.
// No dependencies.
package mfrp_pkg;

  localparam int COORD_W    = 10;
  localparam int COORD_SPAN = 512;
  localparam int ROT_W      = 2;
  localparam int REQ_W      = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [7:0] BYTE_BLACK   = 8'hFF;
  localparam logic [7:0] BYTE_WHITE   = 8'h00;
  localparam logic [7:0] PIX_MSB_MASK = 8'h80;

  typedef enum logic [REQ_W-1:0] {
    REQ_DRAW = 2'd0,
    REQ_FILL = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_ADDR,
    ST_READ,
    ST_WRITE,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic map;
    logic addr;
    logic mem_rd;
    logic mem_wr;
    logic sweep_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic req_draw;
    logic req_fill;
    logic req_read;
    logic access_ok;
    logic sweep_last;
  } sts_t;

endpackage

[rtl/mono_framebuffer_rotated_pixel_engine.sv]
// Top level of the monochrome rotated frame store engine.
// Instantiates mfrp_ctrl and mfrp_dp; uses mfrp_pkg.
//
// This block keeps a one-bit-per-pixel image of PANEL_WIDTH by PANEL_HEIGHT
// pixels, packed most significant bit first with (PANEL_WIDTH+7)/8 bytes per
// row, in a single-port byte memory. A draw transaction checks its coordinates
// against the rotated panel size, maps them through the rotation register and
// sets (black) or clears (white) one bit; an off-panel draw is dropped and
// answered with status 1. A fill transaction writes every byte, and a read
// transaction returns the inverted stored byte, or 0xFF outside the store.
// Every request transaction yields exactly one result transaction. Requests
// are handled one at a time; the next one is taken while the previous result
// still waits in the output register. A draw or a read passes a mapping
// step, an address step (row times row bytes, plus column) and the registered
// read of the memory port, with a draw adding its write-back step. An
// off-panel draw or an out-of-store read skips the memory access, and the
// unused request code skips the address step as well. A fill sweeps the
// memory one byte per cycle. After reset the same sweep clears the store to
// white; no request is accepted during that pass, while rotation writes are
// taken at any time.
module mono_framebuffer_rotated_pixel_engine #(
  parameter int PANEL_WIDTH  = 200,
  parameter int PANEL_HEIGHT = 200
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Rotation register write: cfg_wr_data is the rotation in quarter turns.
  input  logic                            cfg_wr_en,
  input  logic [mfrp_pkg::ROT_W-1:0]      cfg_wr_data,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata fields from bit 0: pix_x[9:0], pix_y[19:10], color[20], zero pad.
  input  logic [mfrp_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser fields from bit 0: req_type[1:0].
  input  logic [mfrp_pkg::REQ_W-1:0]      in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata fields from bit 0: read_byte[7:0], status[8], zero pad.
  output logic [mfrp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mfrp_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] read_byte;
  logic       status;

  mfrp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mfrp_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_req_type   (in_tuser),
    .in_pix_x      (in_tdata[COORD_W-1:0]),
    .in_pix_y      (in_tdata[2*COORD_W-1:COORD_W]),
    .in_color      (in_tdata[2*COORD_W]),
    .cmd           (cmd),
    .sts           (sts),
    .out_read_byte (read_byte),
    .out_status    (status)
  );

  // The result word carries the byte, then the status flag, then zero padding.
  assign out_tdata = {{(OUT_DATA_W - 9){1'b0}}, status, read_byte};

`ifndef ASSERT_OFF
  // The write port never serves a sweep and a read-modify-write at once.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_wr && cmd.sweep_step))
    else $error("sweep and pixel write collide on the store write port");

  // A new request is never taken while the store is being swept or written.
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!cmd.sweep_step && !cmd.mem_wr))
    else $error("request accepted during a store access");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

  // Each pixel write-back directly follows the read of the same byte.
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> $past(cmd.mem_rd))
    else $error("pixel write-back without preceding read");
`endif

endmodule

[rtl/mfrp_ctrl.sv]
// Controller state machine of the frame store engine.
// Sequences request handling, store sweeps and the result register; uses mfrp_pkg.
module mfrp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  mfrp_pkg::sts_t sts,
  output mfrp_pkg::cmd_t cmd
);
  import mfrp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map = 1'b1;
        if (sts.req_draw || sts.req_read) state_nxt = ST_ADDR;
        else if (sts.req_fill) state_nxt = ST_FILL;
        else state_nxt = ST_RESP;
      end
      ST_ADDR: begin
        cmd.addr = 1'b1;
        if (sts.access_ok) state_nxt = ST_READ;
        else state_nxt = ST_RESP;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        if (sts.req_draw) state_nxt = ST_WRITE;
        else state_nxt = ST_RESP;
      end
      ST_WRITE: begin
        cmd.mem_wr = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_FILL: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

[rtl/mfrp_dp.sv]
// Datapath of the frame store engine: request registers, rotation mapping, address
// arithmetic, the byte-wide frame store memory and the result register; uses mfrp_pkg.
module mfrp_dp #(
  parameter int PANEL_WIDTH  = 200,
  parameter int PANEL_HEIGHT = 200
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mfrp_pkg::ROT_W-1:0]   cfg_wr_data,
  input  logic [mfrp_pkg::REQ_W-1:0]   in_req_type,
  input  logic [mfrp_pkg::COORD_W-1:0] in_pix_x,
  input  logic [mfrp_pkg::COORD_W-1:0] in_pix_y,
  input  logic                         in_color,
  input  mfrp_pkg::cmd_t               cmd,
  output mfrp_pkg::sts_t               sts,
  output logic [7:0]                   out_read_byte,
  output logic                         out_status
);
  import mfrp_pkg::*;

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int IDX_W       = $clog2(COORD_SPAN * ROW_BYTES + COORD_SPAN);
  localparam int POS_W       = COORD_W - 1;

  logic [7:0] mem [STORE_BYTES];

  logic [ROT_W-1:0]   rot_r;
  logic [REQ_W-1:0]   req_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic               col_r;
  logic [7:0]         fill_byte_r;
  logic [ADDR_W-1:0]  sweep_r;

  logic [IDX_W-1:0]   prod_r;
  logic [POS_W-1:0]   colterm_r;
  logic [2:0]         bit_r;
  logic               oob_r, rd_neg_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               access_ok_r;
  logic [7:0]         rdata_r;
  logic [7:0]         read_byte_r;
  logic               status_r;

  logic [COORD_W-1:0] w_lim, h_lim;
  logic               oob;
  logic [POS_W-1:0]   xu, yu, px, py, row_sel, colterm;
  logic [IDX_W-1:0]   idx;
  logic               in_store, access_ok;
  logic [7:0]         pix_mask, new_byte;

  // Mapping and bounds stage.
  always_comb begin
    w_lim = rot_r[0] ? COORD_W'(PANEL_HEIGHT) : COORD_W'(PANEL_WIDTH);
    h_lim = rot_r[0] ? COORD_W'(PANEL_WIDTH) : COORD_W'(PANEL_HEIGHT);
    xu    = x_r[POS_W-1:0];
    yu    = y_r[POS_W-1:0];
    oob   = x_r[COORD_W-1] || y_r[COORD_W-1] ||
            ({1'b0, xu} >= w_lim) || ({1'b0, yu} >= h_lim);
    unique case (rot_r)
      2'd1: begin
        px = POS_W'(PANEL_WIDTH - 1) - yu;
        py = xu;
      end
      2'd2: begin
        px = POS_W'(PANEL_WIDTH - 1) - xu;
        py = POS_W'(PANEL_HEIGHT - 1) - yu;
      end
      2'd3: begin
        px = yu;
        py = POS_W'(PANEL_HEIGHT - 1) - xu;
      end
      default: begin
        px = xu;
        py = yu;
      end
    endcase
    if (req_r == REQ_DRAW) begin
      row_sel = py;
      colterm = {3'b000, px[POS_W-1:3]};
    end else begin
      row_sel = yu;
      colterm = xu;
    end
  end

  // Address stage.
  always_comb begin
    idx      = prod_r + IDX_W'(colterm_r);
    in_store = idx < IDX_W'(STORE_BYTES);
    if (req_r == REQ_DRAW) access_ok = !oob_r;
    else access_ok = !rd_neg_r && in_store;
  end

  always_comb begin
    pix_mask = PIX_MSB_MASK >> bit_r;
    new_byte = col_r ? (rdata_r & ~pix_mask) : (rdata_r | pix_mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r       <= '0;
      fill_byte_r <= BYTE_WHITE;
      sweep_r     <= '0;
    end else begin
      if (cfg_wr_en) rot_r <= cfg_wr_data;
      if (cmd.load) begin
        sweep_r     <= '0;
        fill_byte_r <= in_color ? BYTE_WHITE : BYTE_BLACK;
      end else if (cmd.sweep_step) begin
        sweep_r <= sweep_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      x_r   <= in_pix_x;
      y_r   <= in_pix_y;
      col_r <= in_color;
    end
    if (cmd.map) begin
      prod_r    <= IDX_W'(row_sel) * IDX_W'(ROW_BYTES);
      colterm_r <= colterm;
      bit_r     <= px[2:0];
      oob_r     <= oob;
      rd_neg_r  <= x_r[COORD_W-1] || y_r[COORD_W-1];
    end
    if (cmd.addr) begin
      addr_r      <= idx[ADDR_W-1:0];
      access_ok_r <= access_ok;
    end
    if (cmd.out_load) begin
      if (req_r == REQ_READ) read_byte_r <= access_ok_r ? ~rdata_r : BYTE_BLACK;
      else read_byte_r <= 8'h00;
      status_r <= (req_r == REQ_DRAW) && oob_r;
    end
  end

  // Frame store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) mem[sweep_r] <= fill_byte_r;
    else if (cmd.mem_wr) mem[addr_r] <= new_byte;
    if (cmd.mem_rd) rdata_r <= mem[addr_r];
  end

  always_comb begin
    sts.req_draw   = (req_r == REQ_DRAW);
    sts.req_fill   = (req_r == REQ_FILL);
    sts.req_read   = (req_r == REQ_READ);
    sts.access_ok  = access_ok;
    sts.sweep_last = (sweep_r == ADDR_W'(STORE_BYTES - 1));
  end

  assign out_read_byte = read_byte_r;
  assign out_status    = status_r;

endmodule

[dv/tb_mono_framebuffer_rotated_pixel_engine.sv]
// Self-checking testbench for mono_framebuffer_rotated_pixel_engine.
// It shadows the frame store and the rotation register in a small scoreboard
// class and checks every result against it. It depends on rtl/mfrp_pkg.sv.
`timescale 1ns / 1ps

module tb_mono_framebuffer_rotated_pixel_engine;
  import mfrp_pkg::*;

  localparam int PANEL_W   = 200;
  localparam int PANEL_H   = 200;
  localparam int ROW_BYTES = (PANEL_W + 7) / 8;

  // The fourth request code is not in the package enum; the block must answer
  // it with an all-zero result and leave the store alone.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // One result transaction as the scoreboard expects it.
  typedef struct packed {
    logic [7:0] read_byte;
    logic       status;
  } pixel_result_t;

  // The scoreboard keeps its own copy of the image and of the rotation, works
  // out the answer to each accepted request at once, and queues it until the
  // matching result transaction comes out of the block.
  class frame_scoreboard;
    localparam int WIDTH       = 200;
    localparam int HEIGHT      = 200;
    localparam int ROW_LEN     = (WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_LEN * HEIGHT;

    logic [7:0]    shadow [STORE_BYTES];
    logic [1:0]    rotation;
    pixel_result_t awaited_results [$];
    int            errors;

    function void clear();
      foreach (shadow[i]) shadow[i] = BYTE_WHITE;
      rotation = 2'd0;
      errors   = 0;
      awaited_results.delete();
    endfunction

    function void apply_request(input logic [REQ_W-1:0] req, input logic [9:0] x_bits,
                                input logic [9:0] y_bits, input logic color);
      int            x;
      int            y;
      int            w;
      int            h;
      int            px;
      int            py;
      int            idx;
      pixel_result_t res;
      x   = $signed(x_bits);
      y   = $signed(y_bits);
      res = '0;
      if (req == REQ_DRAW) begin
        // Odd quarter turns swap the logical width and height.
        w = rotation[0] ? HEIGHT : WIDTH;
        h = rotation[0] ? WIDTH : HEIGHT;
        if (x < 0 || x >= w || y < 0 || y >= h) begin
          res.status = 1'b1;
        end else begin
          case (rotation)
            2'd1: begin
              px = WIDTH - 1 - y;
              py = x;
            end
            2'd2: begin
              px = WIDTH - 1 - x;
              py = HEIGHT - 1 - y;
            end
            2'd3: begin
              px = y;
              py = HEIGHT - 1 - x;
            end
            default: begin
              px = x;
              py = y;
            end
          endcase
          idx = px / 8 + py * ROW_LEN;
          if (color) begin
            shadow[idx] = shadow[idx] & ~(PIX_MSB_MASK >> (px % 8));
          end else begin
            shadow[idx] = shadow[idx] | (PIX_MSB_MASK >> (px % 8));
          end
        end
      end else if (req == REQ_FILL) begin
        foreach (shadow[i]) shadow[i] = color ? BYTE_WHITE : BYTE_BLACK;
      end else if (req == REQ_READ) begin
        // Reads use a flat byte index, so a column past the row end wraps.
        res.read_byte = 8'hFF;
        if (x >= 0 && y >= 0) begin
          idx = y * ROW_LEN + x;
          if (idx < STORE_BYTES) res.read_byte = ~shadow[idx];
        end
      end
      awaited_results.push_back(res);
    endfunction

    function void check_result(input logic [OUT_DATA_W-1:0] data);
      pixel_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result transaction 0x%04h arrived with no request pending", data);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (data[7:0] !== want.read_byte) begin
          $error("read_byte mismatch: expected 0x%02h, actual 0x%02h", want.read_byte,
                 data[7:0]);
          errors++;
        end
        if (data[8] !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, data[8]);
          errors++;
        end
      end
    endfunction
  endclass

  // Every input starts at a known value at time zero; reset is held low from
  // the first edge on.
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [ROT_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [REQ_W-1:0]      in_tuser    = '0;
  logic                  out_tready  = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Idling rates in percent, changed per phase by the stimulus process.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  frame_scoreboard sb;

  mono_framebuffer_rotated_pixel_engine #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side. Sampling at the edge sees the values from before the edge,
  // so the handshake is judged exactly as the block judges it. The ready for
  // the next cycle is drawn once per edge, which keeps it to one assignment.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Presents one request and holds it until the block takes it. Idle cycles
  // are inserted ahead of it at the current sender rate. The valid is left
  // high after acceptance so that back-to-back requests never lower and
  // raise it within the same time step.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [9:0] x,
                              input logic [9:0] y, input logic color);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, color, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_request(req, x, y, color);
  endtask

  // Stops sending and waits until every expected result has come back, plus
  // a few cycles of margin, so that the block is idle afterwards.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The rotation register is only changed while the block is idle.
  task automatic set_rotation(input logic [1:0] rot);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rot;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.rotation = rot;
  endtask

  // One random request. Half the draws land in a 16 by 16 window at a logical
  // corner and most reads hit the bytes at the panel corners, so reads often
  // see pixels drawn just before under any rotation. The rest is wide random
  // content, including off-panel coordinates, wrapping byte columns, rare
  // fills and the unused request code.
  task automatic random_request();
    int         pick;
    int         sel;
    int         w;
    int         h;
    logic [9:0] x;
    logic [9:0] y;
    logic       color;
    pick  = $urandom_range(99);
    sel   = $urandom_range(9);
    color = 1'($urandom_range(1));
    x     = 10'($urandom);
    y     = 10'($urandom);
    w     = sb.rotation[0] ? PANEL_H : PANEL_W;
    h     = sb.rotation[0] ? PANEL_W : PANEL_H;
    if (pick == 0) begin
      send_request(REQ_FILL, x, y, color);
    end else if (pick < 3) begin
      send_request(REQ_UNUSED, x, y, color);
    end else if (pick < 55) begin
      if (sel < 5) begin
        x = 10'($urandom_range(15));
        y = 10'($urandom_range(15));
        if ($urandom_range(1) == 1) x = 10'(w - 1) - x;
        if ($urandom_range(1) == 1) y = 10'(h - 1) - y;
      end else if (sel < 8) begin
        x = 10'($urandom_range(w - 1));
        y = 10'($urandom_range(h - 1));
      end
      send_request(REQ_DRAW, x, y, color);
    end else begin
      if (sel < 6) begin
        case ($urandom_range(3))
          0: x = 10'd0;
          1: x = 10'd1;
          2: x = 10'(ROW_BYTES - 2);
          default: x = 10'(ROW_BYTES - 1);
        endcase
        y = 10'($urandom_range(15));
        if ($urandom_range(1) == 1) y = 10'(PANEL_H - 1) - y;
      end else if (sel < 8) begin
        x = 10'($urandom_range(ROW_BYTES + 5));
        y = 10'($urandom_range(PANEL_H - 1));
      end
      send_request(REQ_READ, x, y, color);
    end
  endtask

  initial begin : stimulus
    int phase;
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, unrotated first. The block clears its store after reset
    // and holds off requests meanwhile; the first send simply waits for it.
    set_rotation(2'd0);
    send_request(REQ_READ, 10'd0, 10'd0, 1'b0);           // white after reset
    send_request(REQ_DRAW, 10'd0, 10'd0, 1'b0);           // top-left pixel black
    send_request(REQ_READ, 10'd0, 10'd0, 1'b0);
    send_request(REQ_DRAW, 10'd199, 10'd199, 1'b0);       // bottom-right pixel
    send_request(REQ_READ, 10'd24, 10'd199, 1'b1);
    send_request(REQ_DRAW, 10'd199, 10'd199, 1'b1);       // cleared again
    send_request(REQ_READ, 10'd24, 10'd199, 1'b0);
    // Draws off the panel are dropped and flagged.
    send_request(REQ_DRAW, 10'h3FF, 10'd0, 1'b0);
    send_request(REQ_DRAW, 10'd0, 10'd200, 1'b0);
    send_request(REQ_DRAW, 10'h200, 10'h1FF, 1'b1);
    // Reads outside the store answer 0xFF; a column past the row end wraps.
    send_request(REQ_READ, 10'h3FF, 10'd0, 1'b0);
    send_request(REQ_READ, 10'd0, 10'h200, 1'b0);
    send_request(REQ_READ, 10'h1FF, 10'h1FF, 1'b1);
    send_request(REQ_READ, 10'd25, 10'd0, 1'b0);
    send_request(REQ_UNUSED, 10'h3FF, 10'h3FF, 1'b1);
    // Black fill, then white fill.
    send_request(REQ_FILL, 10'd0, 10'd0, 1'b0);
    send_request(REQ_READ, 10'd0, 10'd0, 1'b0);
    send_request(REQ_READ, 10'd24, 10'd199, 1'b0);
    send_request(REQ_FILL, 10'h3FF, 10'h3FF, 1'b1);
    send_request(REQ_READ, 10'd0, 10'd0, 1'b0);
    // Logical origin under each remaining rotation lands at another corner.
    set_rotation(2'd1);
    send_request(REQ_DRAW, 10'd0, 10'd0, 1'b0);
    send_request(REQ_READ, 10'd24, 10'd0, 1'b0);
    set_rotation(2'd3);
    send_request(REQ_DRAW, 10'd0, 10'd0, 1'b0);
    send_request(REQ_READ, 10'd0, 10'd199, 1'b0);
    set_rotation(2'd2);
    send_request(REQ_DRAW, 10'd0, 10'd0, 1'b0);
    send_request(REQ_READ, 10'd24, 10'd199, 1'b0);

    // Random part: eight phases, each setting a rotation and an idling mix; both repeat every four phases.
    for (phase = 0; phase < 8; phase++) begin
      set_rotation(2'((phase * 3 + 1) % 4));
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 50;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 50;
        end
        default: begin
          sender_idle_pct    = 31;
          receiver_stall_pct = 31;
        end
      endcase
      repeat (250) random_request();
    end

    // Let every outstanding result drain, then watch a while longer so that
    // any stray result transaction is caught.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard limit on run time, far beyond the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
